[hw/rtl/orel_pkg.sv]
// Package for the overwrite ring event log: sizes, operation codes, beat types
// and ring position helpers. No dependencies.
`default_nettype none

package orel_pkg;

   // Ring storage size and stored payload width
   localparam int DEPTH         = 256;
   localparam int PAYLOAD_WIDTH = 32;

   // Derived sizes
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SEQ_W     = 64;
   localparam int MEM_W     = SEQ_W + PAYLOAD_WIDTH;
   localparam int CAP_W     = 9;
   localparam int CAP_LIMIT = (DEPTH < 511) ? DEPTH : 511;

   // Operation codes
   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_NOP    = 2'd3;

   // Result status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] event_payload;
      logic [7:0]  read_index;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] entry_payload;
      logic [63:0] entry_sequence;
      logic [8:0]  entry_count;
      logic [63:0] log_revision;
   } rsp_type;

   // Fold a position below twice the capacity back into the ring
   function automatic logic [CAP_W-1:0] ring_wrap(input logic [CAP_W:0] pos,
                                                 input logic [CAP_W-1:0] cap);
      logic [CAP_W:0] diff;
      diff = pos - {1'b0, cap};
      return (pos >= {1'b0, cap}) ? diff[CAP_W-1:0] : pos[CAP_W-1:0];
   endfunction

   // Ring position to memory address
   function automatic logic [ADDR_W-1:0] to_addr(input logic [CAP_W-1:0] pos);
      logic [ADDR_W+CAP_W-1:0] wide;
      wide = {{ADDR_W{1'b0}}, pos};
      return wide[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/overwrite_ring_event_log_top.sv]
// Top level of the overwrite ring event log: ring control, counters and result
// staging around one entry RAM. Uses orel_pkg and orel_ram.
`default_nettype none

// Channel  | Ports                            | Beat
// ---------+----------------------------------+--------------------------------
// request  | req_valid, req_ready, req_data   | req_type: kind, payload, index
// response | rsp_valid, rsp_ready, rsp_data   | rsp_type: one result per request
// csr      | csr_valid, csr_ready, csr_data   | capacity_in_use, 9 bits
//
// One request beat per cycle is taken while the response is not stalled; its result
// passes through the RAM read stage and then the output register.
// Ring pointers and counters update when the request is taken, so every
// request sees the writes of all earlier ones; no forwarding is needed.
// A stalled response backs up into the read stage and then holds off requests.
// Reset: empty ring, capacity 256, sequence 1, revision 0. No clearing pass.

module overwrite_ring_event_log_top
   import orel_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CAP_W-1:0] csr_data
);

   localparam logic [CAP_W-1:0] CAP_LIMIT_V = CAP_W'(CAP_LIMIT);

   // Control state
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CAP_W-1:0] oldest_ff, oldest_in;
   logic [CAP_W-1:0] held_ff, held_in;
   logic [SEQ_W-1:0] stamp_ff, stamp_in;
   logic [63:0]      rev_ff, rev_in;

   // Read stage
   logic             s1_vld_ff, s1_vld_in;
   logic             s1_hit_ff;
   logic             s1_status_ff;
   logic [CAP_W-1:0] s1_count_ff;
   logic [63:0]      s1_rev_ff;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic              accept, move;
   logic [CAP_W-1:0]  eff_cap;
   logic              wr_en, rd_en, status;
   logic [CAP_W-1:0]  wr_pos, rd_pos;
   logic [MEM_W-1:0]  wr_word, rd_word;
   logic [PAYLOAD_WIDTH+31:0] pl_in_wide, pl_out_wide;

   // Handshakes
   assign move      = s1_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || move;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Capacity in force: zero means one, clipped to the ring size
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (capacity_ff > CAP_LIMIT_V) begin
         eff_cap = CAP_LIMIT_V;
      end else begin
         eff_cap = capacity_ff;
      end
   end

   // Operation decode and ring pointer update
   always_comb begin
      capacity_in = capacity_ff;
      oldest_in   = oldest_ff;
      held_in     = held_ff;
      stamp_in    = stamp_ff;
      rev_in      = rev_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      wr_pos      = ring_wrap({1'b0, oldest_ff} + {1'b0, held_ff}, eff_cap);
      rd_pos      = ring_wrap({1'b0, oldest_ff} + {2'b0, req_data.read_index}, eff_cap);
      status      = STATUS_OK;
      if (accept) begin
         case (req_data.kind)
            KIND_APPEND: begin
               wr_en    = 1'b1;
               stamp_in = stamp_ff + 64'd1;
               rev_in   = rev_ff + 64'd1;
               if (held_ff == eff_cap) begin
                  // full: overwrite the oldest entry
                  wr_pos    = oldest_ff;
                  oldest_in = ring_wrap({1'b0, oldest_ff} + 10'd1, eff_cap);
               end else begin
                  held_in = held_ff + 9'd1;
               end
            end
            KIND_READ: begin
               if ({1'b0, req_data.read_index} >= held_ff) begin
                  status = STATUS_NOT_FOUND;
               end else begin
                  rd_en = 1'b1;
               end
            end
            KIND_CLEAR: begin
               held_in   = '0;
               oldest_in = '0;
               rev_in    = rev_ff + 64'd1;
            end
            default: begin
            end
         endcase
      end
      // capacity writes are to arrive only while idle; the block itself does not enforce this
      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
         held_in     = '0;
         oldest_in   = '0;
      end
   end

   // Payload sized to the stored width and back to the beat width
   assign pl_in_wide = {{PAYLOAD_WIDTH{1'b0}}, req_data.event_payload};
   assign wr_word    = {stamp_ff, pl_in_wide[PAYLOAD_WIDTH-1:0]};
   assign pl_out_wide = {32'b0, rd_word[PAYLOAD_WIDTH-1:0]};

   orel_ram #(
      .WIDTH(MEM_W),
      .DEPTH(DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(to_addr(wr_pos)),
      .wr_data(wr_word),
      .rd_en  (rd_en),
      .rd_addr(to_addr(rd_pos)),
      .rd_data(rd_word)
   );

   // Stage valid and output register
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (move) begin
         s1_vld_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (move) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.status         = s1_status_ff;
         rsp_data_in.entry_payload  = s1_hit_ff ? pl_out_wide[31:0] : 32'd0;
         rsp_data_in.entry_sequence = s1_hit_ff ? rd_word[MEM_W-1:PAYLOAD_WIDTH] : 64'd0;
         rsp_data_in.entry_count    = s1_count_ff;
         rsp_data_in.log_revision   = s1_rev_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_W'(256);
         oldest_ff    <= '0;
         held_ff      <= '0;
         stamp_ff     <= 64'd1;
         rev_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         stamp_ff     <= stamp_in;
         rev_ff       <= rev_in;
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hit_ff    <= rd_en;
         s1_status_ff <= status;
         s1_count_ff  <= held_in;
         s1_rev_ff    <= rev_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_held_in_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= eff_cap)
      else $error("entry count above capacity");

   a_oldest_in_ring: assert property (@(posedge clock) disable iff (reset)
      oldest_ff < eff_cap)
      else $error("oldest position outside ring");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && rsp_valid_ff && !rsp_ready |=> s1_vld_ff && $stable(s1_count_ff))
      else $error("read stage dropped a stalled result");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken with both stages full");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff)
      else $error("accepted request lost");

endmodule

`default_nettype wire

[hw/rtl/orel_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered,
// enabled read data. No dependencies.
`default_nettype none

module orel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
